// ----- hw/rtl/u8v_pkg.sv -----
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8v_pkg;

  // Byte classes produced by the front end
  typedef enum logic [2:0] {
    KIND_ASCII = 3'd0,
    KIND_LEAD2 = 3'd1,
    KIND_LEAD3 = 3'd2,
    KIND_LEAD4 = 3'd3,
    KIND_CONT  = 3'd4,
    KIND_BAD   = 3'd5
  } byte_kind_t;

  // One classified byte as it travels through the queue
  typedef struct packed {
    byte_kind_t  kind;
    logic [5:0]  bits;   // payload bits of a lead or continuation byte
    logic        last;
  } item_t;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_MIN2    = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
  localparam logic [CP_W-1:0] CP_SUR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SUR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;

endpackage

`default_nettype wire

// ----- hw/rtl/u8v_front.sv -----
// ----------------------------------------------------------------------------
// u8v_front
// Accepts raw bytes and classifies them (lead, continuation, ASCII, bad)
// before pushing them into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8v_front (
  input  wire logic           in_valid,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic           in_last_byte,
  output logic                in_stall,
  input  wire logic           q_full,
  output logic                q_push,
  output u8v_pkg::item_t      q_item
);

  u8v_pkg::byte_kind_t kind;
  logic [5:0]          bits;

  always_comb begin
    kind = u8v_pkg::KIND_BAD;
    bits = 6'd0;
    if (in_data_byte[7] == 1'b0) begin
      kind = u8v_pkg::KIND_ASCII;
    end else if (in_data_byte[7:6] == 2'b10) begin
      kind = u8v_pkg::KIND_CONT;
      bits = in_data_byte[5:0];
    end else if (in_data_byte[7:5] == 3'b110) begin
      kind = u8v_pkg::KIND_LEAD2;
      bits = {1'b0, in_data_byte[4:0]};
    end else if (in_data_byte[7:4] == 4'b1110) begin
      kind = u8v_pkg::KIND_LEAD3;
      bits = {2'b00, in_data_byte[3:0]};
    end else if (in_data_byte[7:3] == 5'b11110) begin
      kind = u8v_pkg::KIND_LEAD4;
      bits = {3'b000, in_data_byte[2:0]};
    end
  end

  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_item.kind = kind;
  assign q_item.bits = bits;
  assign q_item.last = in_last_byte;

endmodule

`default_nettype wire

// ----- hw/rtl/u8v_queue.sv -----
// ----------------------------------------------------------------------------
// u8v_queue
// Small register FIFO of classified bytes between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8v_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire u8v_pkg::item_t  push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output u8v_pkg::item_t       head_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8v_pkg::item_t    mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

endmodule

`default_nettype wire

// ----- hw/rtl/u8v_back.sv -----
// ----------------------------------------------------------------------------
// u8v_back
// Decode state machine: builds code points, latches errors and registers
// the per-message verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8v_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_not_empty,
  input  wire u8v_pkg::item_t  q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_valid_res
);

  logic [1:0]                 pend_r, pend_nxt;
  logic [1:0]                 len_r, len_nxt;
  logic [u8v_pkg::CP_W-1:0]   acc_r, acc_nxt;
  logic                       err_r, err_nxt;
  logic                       ovld_r, ovld_nxt;
  logic                       ores_r, ores_nxt;
  logic [u8v_pkg::CP_W-1:0]   cp;
  logic [1:0]                 pend_dec;
  logic                       cp_bad;

  // a byte without a verdict can always move; a last byte needs the output slot
  assign q_pop = q_not_empty && (!q_item.last || !ovld_r || !out_stall);

  assign cp       = {acc_r[u8v_pkg::CP_W-7:0], q_item.bits};
  assign pend_dec = pend_r - 2'd1;

  always_comb begin
    cp_bad = 1'b0;
    if (len_r == 2'd1 && cp < u8v_pkg::CP_MIN2) cp_bad = 1'b1;
    if (len_r == 2'd2 && cp < u8v_pkg::CP_MIN3) cp_bad = 1'b1;
    if (len_r == 2'd3 && cp < u8v_pkg::CP_MIN4) cp_bad = 1'b1;
    if (cp >= u8v_pkg::CP_SUR_LO && cp <= u8v_pkg::CP_SUR_HI) cp_bad = 1'b1;
    if (cp > u8v_pkg::CP_MAX) cp_bad = 1'b1;
  end

  always_comb begin
    pend_nxt = pend_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    err_nxt  = err_r;
    ovld_nxt = ovld_r && out_stall;
    ores_nxt = ores_r;

    if (q_pop) begin
      if (!err_r) begin
        if (pend_r == 2'd0) begin
          unique case (q_item.kind)
            u8v_pkg::KIND_ASCII: ;
            u8v_pkg::KIND_LEAD2: begin
              acc_nxt  = u8v_pkg::CP_W'(q_item.bits);
              len_nxt  = 2'd1;
              pend_nxt = 2'd1;
            end
            u8v_pkg::KIND_LEAD3: begin
              acc_nxt  = u8v_pkg::CP_W'(q_item.bits);
              len_nxt  = 2'd2;
              pend_nxt = 2'd2;
            end
            u8v_pkg::KIND_LEAD4: begin
              acc_nxt  = u8v_pkg::CP_W'(q_item.bits);
              len_nxt  = 2'd3;
              pend_nxt = 2'd3;
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end else if (q_item.kind != u8v_pkg::KIND_CONT) begin
          err_nxt = 1'b1;
        end else begin
          acc_nxt  = cp;
          pend_nxt = pend_dec;
          if (pend_dec == 2'd0) begin
            if (cp_bad) begin
              err_nxt = 1'b1;
            end else begin
              len_nxt = 2'd0;
              acc_nxt = '0;
            end
          end
        end
        if (err_nxt) begin
          pend_nxt = 2'd0;
          len_nxt  = 2'd0;
          acc_nxt  = '0;
        end
      end

      if (q_item.last) begin
        ovld_nxt = 1'b1;
        ores_nxt = !err_nxt && (pend_nxt == 2'd0);
        pend_nxt = 2'd0;
        len_nxt  = 2'd0;
        acc_nxt  = '0;
        err_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      len_r  <= 2'd0;
      acc_r  <= '0;
      err_r  <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
      err_r  <= err_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ores_r <= ores_nxt;
  end

  assign out_valid     = ovld_r;
  assign out_valid_res = ores_r;

  a_err_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (pend_r == 2'd0 && len_r == 2'd0))
    else $error("pending bytes with error latched");

  a_pend_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= len_r)
    else $error("pending count exceeds sequence length");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.last) |=> (ovld_r && pend_r == 2'd0 && !err_r))
    else $error("last byte did not produce a verdict or clear state");

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_stream_validator.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 checker for a byte stream with a last-byte marker.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, sustained, as long as the verdict output is not
// held off. Bytes are classified on entry and pass through a QUEUE_DEPTH-entry
// queue to the decode stage, which updates the registered sequence state as
// each byte is popped. With the queue empty, the last byte of a message is
// first written into the queue and then popped by the decoder, which
// registers out_valid and the verdict. While a verdict waits on out_stall the
// decoder keeps consuming non-final bytes, so input stalls only once the queue
// fills behind a second final byte.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_validator #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_valid_res
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_not_empty;
  u8v_pkg::item_t  push_item;
  u8v_pkg::item_t  head_item;

  u8v_front u_front (
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  u8v_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  u8v_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res)
  );

endmodule

`default_nettype wire

// ----- sim/utf8_verdict_checker.sv -----
// ----------------------------------------------------------------------------
// utf8_verdict_checker
// Watches both channels of the UTF-8 stream validator, decodes every accepted
// byte on its own and checks each message verdict against the expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_verdict_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_valid_res,
  output int               fail_count,
  output int               verdicts_owed
);

  // decoder state, mirrors the block
  logic [1:0]  cont_left = '0;
  logic [1:0]  seq_len   = '0;
  logic [20:0] cp_acc    = '0;
  logic        msg_bad   = 1'b0;

  logic verdict_q[$];
  int   fails = 0;
  int   owed  = 0;

  assign fail_count    = fails;
  assign verdicts_owed = owed;

  task automatic mark_bad();
    msg_bad   = 1'b1;
    cont_left = '0;
    seq_len   = '0;
    cp_acc    = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [20:0] cp;
    logic        bad;
    if (msg_bad) return;  // nothing is decoded once an error is latched
    if (cont_left == 2'd0) begin
      if (!b[7]) return;
      if (b[7:5] == 3'b110) begin
        cp_acc  = {16'd0, b[4:0]};
        seq_len = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc  = {17'd0, b[3:0]};
        seq_len = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc  = {18'd0, b[2:0]};
        seq_len = 2'd3;
      end else begin
        mark_bad();
        return;
      end
      cont_left = seq_len;
    end else begin
      if (b[7:6] != 2'b10) begin
        mark_bad();
        return;
      end
      cp_acc    = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left != 2'd0) return;
      cp  = cp_acc;
      bad = (seq_len == 2'd1 && cp < u8v_pkg::CP_MIN2) ||
            (seq_len == 2'd2 && cp < u8v_pkg::CP_MIN3) ||
            (seq_len == 2'd3 && cp < u8v_pkg::CP_MIN4) ||
            (cp >= u8v_pkg::CP_SUR_LO && cp <= u8v_pkg::CP_SUR_HI) ||
            (cp > u8v_pkg::CP_MAX);
      if (bad) begin
        mark_bad();
      end else begin
        seq_len = '0;
        cp_acc  = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    logic exp_res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("valid_res transfer with no verdict pending: actual %0b", out_valid_res);
          fails++;
        end else begin
          exp_res = verdict_q.pop_front();
          owed--;
          if (out_valid_res !== exp_res) begin
            $error("valid_res mismatch: expected %0b, actual %0b", exp_res, out_valid_res);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_data_byte);
        if (in_last_byte) begin
          // a sequence still open at the end spoils the message
          if (cont_left != 2'd0) msg_bad = 1'b1;
          verdict_q.push_back(!msg_bad);
          owed++;
          cont_left = '0;
          seq_len   = '0;
          cp_acc    = '0;
          msg_bad   = 1'b0;
        end
      end
    end
  end

endmodule

// ----- sim/utf8_stream_validator_test.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator_test
// Feeds the validator directed edge-case messages, then random messages that
// are mostly well-formed text with some corrupted, truncated or noise ones,
// under random input gaps and output stalls; a checker module scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_validator_test;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       out_valid_res;

  int fail_count;
  int verdicts_owed;

  // {last, byte} per transfer
  logic [8:0] byte_stream[$];
  logic [7:0] msg[$];

  utf8_stream_validator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res)
  );

  utf8_verdict_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .fail_count    (fail_count),
    .verdicts_owed (verdicts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: picks a new stall mode whenever the current mode runs out
  int   stall_mode = 0;
  int   mode_left  = 0;
  int   run_left   = 0;
  logic hold_level = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(50, 300);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          // long runs of stall and release
          if (run_left == 0) begin
            hold_level = ~hold_level;
            run_left   = $urandom_range(1, 12);
          end
          run_left--;
          out_stall <= hold_level;
        end
      endcase
    end
  end

  task automatic flush_message();
    foreach (msg[i]) byte_stream.push_back({(i == msg.size() - 1), msg[i]});
    msg.delete();
  endtask

  task automatic put_code_point(input logic [20:0] cp, input int nbytes);
    case (nbytes)
      1: msg.push_back({1'b0, cp[6:0]});
      2: begin
        msg.push_back({3'b110, cp[10:6]});
        msg.push_back({2'b10, cp[5:0]});
      end
      3: begin
        msg.push_back({4'b1110, cp[15:12]});
        msg.push_back({2'b10, cp[11:6]});
        msg.push_back({2'b10, cp[5:0]});
      end
      default: begin
        msg.push_back({5'b11110, cp[20:18]});
        msg.push_back({2'b10, cp[17:12]});
        msg.push_back({2'b10, cp[11:6]});
        msg.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic put_good_char();
    logic [20:0] cp;
    case ($urandom_range(0, 3))
      0: put_code_point(21'($urandom_range(0, 'h7F)), 1);
      1: put_code_point(21'($urandom_range('h80, 'h7FF)), 2);
      2: begin
        // skip the surrogate block
        cp = 21'($urandom_range('h800, 'hF7FF));
        if (cp >= 21'hD800) cp = cp + 21'h800;
        put_code_point(cp, 3);
      end
      default: put_code_point(21'($urandom_range('h10000, 'h10FFFF)), 4);
    endcase
  endtask

  task automatic put_bad_char();
    int          n;
    logic [7:0]  b;
    case ($urandom_range(0, 5))
      0: begin
        n = $urandom_range(2, 4);
        if (n == 2) put_code_point(21'($urandom_range(0, 'h7F)), 2);
        else if (n == 3) put_code_point(21'($urandom_range(0, 'h7FF)), 3);
        else put_code_point(21'($urandom_range(0, 'hFFFF)), 4);
      end
      1: put_code_point(21'($urandom_range('hD800, 'hDFFF)), 3);
      2: put_code_point(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      3: begin
        if ($urandom_range(0, 1) == 0) msg.push_back(8'($urandom_range('h80, 'hBF)));
        else msg.push_back(8'($urandom_range('hF8, 'hFF)));
      end
      4: begin
        // a lead followed by something that is not a continuation
        msg.push_back(8'($urandom_range('hC2, 'hF4)));
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        msg.push_back(b);
      end
      default: msg.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic add_message();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) put_good_char();
      if (kind >= 65) begin
        case ($urandom_range(0, 2))
          0: begin
            put_bad_char();
            repeat ($urandom_range(0, 2)) put_good_char();
          end
          1: begin
            if (msg.size() > 1) void'(msg.pop_back());
            else msg[0] = 8'hE3;
          end
          default: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    flush_message();
  endtask

  task automatic send_stream();
    logic [8:0] item;
    int         burst_left;
    burst_left = 0;
    while (byte_stream.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      item = byte_stream.pop_front();
      in_valid     <= 1'b1;
      in_data_byte <= item[7:0];
      in_last_byte <= item[8];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, bad leads, overlong, surrogate, too large,
    // largest valid, cut-short sequence, bad continuation, bytes after error
    msg = {8'h00};                      flush_message();
    msg = {8'hFF};                      flush_message();
    msg = {8'h80};                      flush_message();
    msg = {8'hC1, 8'hBF};               flush_message();
    msg = {8'hC2, 8'h80};               flush_message();
    msg = {8'hEF, 8'hBF, 8'hBF};        flush_message();
    msg = {8'hED, 8'hA0, 8'h80};        flush_message();
    msg = {8'hF4, 8'h90, 8'h80, 8'h80}; flush_message();
    msg = {8'hF4, 8'h8F, 8'hBF, 8'hBF}; flush_message();
    msg = {8'hC2};                      flush_message();
    msg = {8'hE1, 8'h41};               flush_message();
    msg = {8'hF8, 8'h41};               flush_message();
    send_stream();

    while (byte_stream.size() < 1950) add_message();
    send_stream();

    while (verdicts_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
